FILE: rtl/rif_pkg.sv
// Shared types, constants and helpers of the radix integer formatter.
package rif_pkg;

  localparam int unsigned NumBits    = 32;
  localparam int unsigned AlphaLen   = 64;
  localparam int unsigned AlphaWords = 8;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned AlphaBits  = AlphaWords * WordBits;
  localparam int unsigned DigitBits  = $clog2(AlphaLen);
  localparam int unsigned RadixBits  = DigitBits + 1;
  localparam int unsigned StackBits  = $clog2(NumBits);
  localparam int unsigned CountBits  = StackBits + 1;
  localparam int unsigned IndexBits  = 8;

  localparam logic [7:0] MinusChar = 8'd45;
  localparam logic [7:0] PlusChar  = 8'd43;
  localparam logic [7:0] LowLimit  = 8'd32;
  localparam logic [7:0] HighLimit = 8'd127;

  typedef logic [AlphaBits-1:0] alpha_t;

  typedef struct packed {
    logic                 busy;
    logic                 ok;
    logic [RadixBits-1:0] radix;
  } alpha_status_t;

  typedef struct packed {
    logic                 start;
    logic [NumBits-1:0]   dividend;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [NumBits-1:0]   quotient;
    logic [DigitBits-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StSign,
    StDivStart,
    StDivWait,
    StEmit
  } fmt_state_e;

  // Pick byte idx out of the alphabet; byte 0 sits in the low bits of word 0.
  function automatic logic [7:0] alpha_byte(input alpha_t a, input logic [DigitBits-1:0] idx);
    return a[{idx, 3'b000} +: 8];
  endfunction

endpackage

FILE: rtl/rif_alpha_check.sv
// Alphabet registers and a serial sweep that finds the radix and checks the digit set.
module rif_alpha_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rif_pkg::IndexBits-1:0]   cfg_index_i,
  input  logic [rif_pkg::WordBits-1:0]    cfg_data_i,
  output rif_pkg::alpha_t                 alpha_o,
  output rif_pkg::alpha_status_t          status_o
);

  logic [rif_pkg::WordBits-1:0]  word_q [rif_pkg::AlphaWords];
  rif_pkg::alpha_t               alpha;
  logic [rif_pkg::DigitBits-1:0] pos_q;
  logic                          busy_q;
  logic                          bad_q;
  logic                          ok_q;
  logic [rif_pkg::RadixBits-1:0] radix_q;
  logic [7:0]                    cur;
  logic                          dup;
  logic                          bad_char;
  logic                          bad_next;

  always_comb begin
    for (int w = 0; w < rif_pkg::AlphaWords; w++) begin
      alpha[w*rif_pkg::WordBits +: rif_pkg::WordBits] = word_q[w];
    end
  end

  assign cur = rif_pkg::alpha_byte(alpha, pos_q);

  // Compare the current byte with every earlier byte; those are all nonzero.
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < rif_pkg::AlphaLen; j++) begin
      if ((rif_pkg::DigitBits'(j) < pos_q) &&
          (rif_pkg::alpha_byte(alpha, rif_pkg::DigitBits'(j)) == cur)) begin
        dup = 1'b1;
      end
    end
  end

  assign bad_char = (cur <= rif_pkg::LowLimit) || (cur >= rif_pkg::HighLimit) ||
                    (cur == rif_pkg::PlusChar) || (cur == rif_pkg::MinusChar);
  assign bad_next = bad_q || bad_char || dup;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < rif_pkg::AlphaWords; w++) begin
        word_q[w] <= '0;
      end
      pos_q   <= '0;
      busy_q  <= 1'b0;
      bad_q   <= 1'b0;
      ok_q    <= 1'b0;
      radix_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i < rif_pkg::IndexBits'(rif_pkg::AlphaWords)) begin
        word_q[cfg_index_i[$clog2(rif_pkg::AlphaWords)-1:0]] <= cfg_data_i;
        pos_q  <= '0;
        busy_q <= 1'b1;
        bad_q  <= 1'b0;
        ok_q   <= 1'b0;
      end
    end else if (busy_q) begin
      if (cur == 8'd0) begin
        busy_q  <= 1'b0;
        radix_q <= {1'b0, pos_q};
        ok_q    <= (pos_q >= rif_pkg::DigitBits'(2)) && !bad_q;
      end else if (pos_q == rif_pkg::DigitBits'(rif_pkg::AlphaLen - 1)) begin
        busy_q  <= 1'b0;
        radix_q <= rif_pkg::RadixBits'(rif_pkg::AlphaLen);
        ok_q    <= !bad_next;
      end else begin
        pos_q <= pos_q + 1'b1;
        bad_q <= bad_next;
      end
    end
  end

  assign alpha_o         = alpha;
  assign status_o.busy   = busy_q;
  assign status_o.ok     = ok_q;
  assign status_o.radix  = radix_q;

endmodule

FILE: rtl/rif_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle by the radix.
module rif_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rif_pkg::RadixBits-1:0]   radix_i,
  input  rif_pkg::div_req_t               req_i,
  output rif_pkg::div_rsp_t               rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [rif_pkg::StackBits-1:0] cnt_q;
  logic [rif_pkg::NumBits-1:0]   quo_q;
  logic [rif_pkg::DigitBits-1:0] rem_q;
  logic [rif_pkg::RadixBits-1:0] trial;
  logic [rif_pkg::RadixBits-1:0] diff;
  logic                          ge;

  assign trial = {rem_q, quo_q[rif_pkg::NumBits-1]};
  assign ge    = (trial >= radix_i);
  assign diff  = trial - radix_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rif_pkg::StackBits'(rif_pkg::NumBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[rif_pkg::NumBits-2:0], ge};
      rem_q <= ge ? diff[rif_pkg::DigitBits-1:0] : trial[rif_pkg::DigitBits-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: rtl/radix_integer_formatter.sv
// Top level of the radix integer formatter: sequencer, digit stack and output register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one signed 32-bit word,
//   number_in_i. Output channel (out_valid_o / out_ready_i) gives one word
//   per character: char_out_o and last_char_o, set on the final digit.
//   A negative number opens with '-'. Digits follow most significant first.
//   Configuration: cfg_we_i writes cfg_data_i into alphabet word cfg_index_i
//   (0 to 7, others dropped). Each write starts a sweep over the alphabet bytes
//   that finds the radix and checks the alphabet; input stalls meanwhile.
//   An invalid alphabet swallows the input word and gives no output.
// Flow:
//   Each digit sends a start to the bit-serial divider, waits while it
//   shifts the dividend through, then collects the result and pushes the
//   remainder on the digit stack; the digits then go out from the stack.
//   One item is in flight at a time; in_ready_o rises once the last
//   character sits in the output register.
// Reset: the alphabet clears to zero, so it is invalid until written.
// Stall: a held output word stalls the sign and emit steps until it is taken.
module radix_integer_formatter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [rif_pkg::NumBits-1:0] number_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      char_out_o,
  output logic                            last_char_o,
  input  logic                            cfg_we_i,
  input  logic [rif_pkg::IndexBits-1:0]   cfg_index_i,
  input  logic [rif_pkg::WordBits-1:0]    cfg_data_i
);

  rif_pkg::alpha_t        alpha;
  rif_pkg::alpha_status_t status;
  rif_pkg::div_req_t      div_req;
  rif_pkg::div_rsp_t      div_rsp;
  rif_pkg::fmt_state_e    state_q, state_d;

  logic [rif_pkg::NumBits-1:0]   mag_q, mag_d;
  logic [rif_pkg::CountBits-1:0] count_q, count_d;
  logic [rif_pkg::DigitBits-1:0] stack_q [rif_pkg::NumBits];
  logic                          push;
  logic [rif_pkg::StackBits-1:0] top_idx;

  logic       out_valid_q;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load;
  logic       slot_free;
  logic       accept;

  rif_alpha_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .alpha_o     (alpha),
    .status_o    (status)
  );

  rif_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .radix_i (status.radix),
    .req_i   (div_req),
    .rsp_o   (div_rsp)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == rif_pkg::StIdle) && !status.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign top_idx    = rif_pkg::StackBits'(count_q - 1'b1);

  // Sequence one item: sign, divide digit by digit, then pop the stack.
  always_comb begin
    state_d          = state_q;
    mag_d            = mag_q;
    count_d          = count_q;
    push             = 1'b0;
    load             = 1'b0;
    char_d           = char_q;
    last_d           = last_q;
    div_req.start    = 1'b0;
    div_req.dividend = mag_q;
    unique case (state_q)
      rif_pkg::StIdle: begin
        if (accept && status.ok) begin
          count_d = '0;
          if (number_in_i[rif_pkg::NumBits-1]) begin
            // Unsigned negate keeps the most negative value as 2^(N-1).
            mag_d   = ~number_in_i + 1'b1;
            state_d = rif_pkg::StSign;
          end else begin
            mag_d   = number_in_i;
            state_d = rif_pkg::StDivStart;
          end
        end
      end
      rif_pkg::StSign: begin
        if (slot_free) begin
          load    = 1'b1;
          char_d  = rif_pkg::MinusChar;
          last_d  = 1'b0;
          state_d = rif_pkg::StDivStart;
        end
      end
      rif_pkg::StDivStart: begin
        div_req.start = 1'b1;
        state_d       = rif_pkg::StDivWait;
      end
      rif_pkg::StDivWait: begin
        if (div_rsp.done) begin
          push    = 1'b1;
          count_d = count_q + 1'b1;
          mag_d   = div_rsp.quotient;
          if ((div_rsp.quotient != '0) &&
              (count_q != rif_pkg::CountBits'(rif_pkg::NumBits - 1))) begin
            state_d = rif_pkg::StDivStart;
          end else begin
            state_d = rif_pkg::StEmit;
          end
        end
      end
      rif_pkg::StEmit: begin
        if (slot_free) begin
          load    = 1'b1;
          char_d  = rif_pkg::alpha_byte(alpha, stack_q[top_idx]);
          last_d  = (count_q == rif_pkg::CountBits'(1));
          count_d = count_q - 1'b1;
          if (count_q == rif_pkg::CountBits'(1)) begin
            state_d = rif_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = rif_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rif_pkg::StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: magnitude, digit stack and output word hold without reset.
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
    if (push) begin
      stack_q[count_q[rif_pkg::StackBits-1:0]] <= div_rsp.remainder;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_char_o = last_q;

endmodule
